@@ sv/mqm_pkg.sv @@
// shared constants, types and state codes for the mean iq magnitude block
package mqm_pkg;

  // samples counted per block at most
  localparam int MAX_SAMPLES = 4096;

  localparam int IQ_W = 8;
  localparam int POW_W = 16;
  localparam int MAG_W = 16;
  localparam int RAD_W = 2 * POW_W;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = CNT_W + MAG_W;
  localparam int ROOT_STEPS = MAG_W;
  localparam int STEP_W = $clog2(SUM_W);

  // power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);

  // one classified sample as it waits between front and back
  typedef struct packed {
    logic [POW_W-1:0] power;
    logic             counted;
    logic             last;
  } sample_t;

  // queue write side and queue head
  typedef struct packed {
    logic    valid;
    sample_t data;
  } q_port_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ sv/mqm_in_if.sv @@
// sample request channel: valid, ready and one complex sample
interface mqm_in_if import mqm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [IQ_W-1:0] in_phase;
  logic signed [IQ_W-1:0] quadrature;
  logic                   block_end;

  modport source (output valid, in_phase, quadrature, block_end, input ready);
  modport sink (input valid, in_phase, quadrature, block_end, output ready);
endinterface

@@ sv/mqm_out_if.sv @@
// result request channel: valid, ready and the block mean
interface mqm_out_if import mqm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] mean_magnitude;

  modport source (output valid, mean_magnitude, input ready);
  modport sink (input valid, mean_magnitude, output ready);
endinterface

@@ sv/mqm_front.sv @@
// front end: accepts samples, forms the power and marks counted samples
module mqm_front import mqm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  mqm_in_if.sink  samples,
  input  logic    q_full,
  output q_port_t push
);

  logic [CNT_W-1:0]         fcount;
  logic                     accept;
  logic                     counted;
  logic signed [2*IQ_W-1:0] isq;
  logic signed [2*IQ_W-1:0] qsq;
  logic [POW_W-1:0]         power;

  // take a request whenever the queue has room
  assign samples.ready = !q_full;
  assign accept = samples.valid && !q_full;

  // power of the sample, at most 32768
  assign isq = samples.in_phase * samples.in_phase;
  assign qsq = samples.quadrature * samples.quadrature;
  assign power = POW_W'($unsigned(isq)) + POW_W'($unsigned(qsq));

  // samples past the limit are passed on but not counted
  assign counted = fcount < MAX_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
    end else if (accept) begin
      if (samples.block_end) begin
        fcount <= '0;
      end else if (counted) begin
        fcount <= fcount + 1'b1;
      end
    end
  end

  // queue write
  always_comb begin
    push.valid        = accept;
    push.data.power   = power;
    push.data.counted = counted;
    push.data.last    = samples.block_end;
  end

endmodule

@@ sv/mqm_queue.sv @@
// short fifo between front and back
module mqm_queue import mqm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_port_t push,
  output logic    full,
  input  logic    pop,
  output q_port_t head
);

  sample_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QPTR_W + 1)'(push.valid) - (QPTR_W + 1)'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.data;
    end
  end

  assign full = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head.valid = fill != '0;
  assign head.data = slots[rd_ptr];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("write into full queue");

endmodule

@@ sv/mqm_back.sv @@
// back end: iterative square root, accumulation, iterative divide, result register
module mqm_back import mqm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_port_t   head,
  output logic      pop,
  mqm_out_if.source result
);

  back_state_t       state;
  back_state_t       state_next;
  logic              load;
  logic [STEP_W-1:0] step;
  logic              last_f;

  logic [RAD_W-1:0]  rad;
  logic [MAG_W+1:0]  rem;
  logic [MAG_W-1:0]  root;
  logic [MAG_W+3:0]  rem_sh;
  logic [MAG_W+1:0]  trial;
  logic              rge;
  logic [MAG_W+3:0]  rem_new;
  logic [MAG_W-1:0]  root_new;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  bcount;

  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  drem;
  logic [CNT_W:0]    dr_sh;
  logic              dge;
  logic [CNT_W:0]    dr_diff;

  logic              outv;
  logic [MAG_W-1:0]  mean;

  // one root digit per cycle
  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign rge = rem_sh >= {2'b00, trial};
  assign rem_new = rge ? rem_sh - {2'b00, trial} : rem_sh;
  assign root_new = {root[MAG_W-2:0], rge};
  assign sum_new = sum + SUM_W'(root_new);

  // one quotient bit per cycle
  assign dr_sh = {drem, dvd[SUM_W-1]};
  assign dge = dr_sh >= {1'b0, bcount};
  assign dr_diff = dr_sh - {1'b0, bcount};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, pop and result load
  always_comb begin
    state_next = state;
    pop = 1'b0;
    load = 1'b0;
    case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.data.counted) begin
            state_next = B_ROOT;
          end else if (head.data.last) begin
            state_next = B_DIV;
          end
        end
      end
      B_ROOT: begin
        if (step == '0) begin
          state_next = last_f ? B_DIV : B_IDLE;
        end
      end
      B_DIV: begin
        if (step == '0) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!outv || result.ready) begin
          load = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // block accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      bcount <= '0;
    end else if (state == B_ROOT && step == '0) begin
      sum    <= sum_new;
      bcount <= bcount + 1'b1;
    end else if (load) begin
      sum    <= '0;
      bcount <= '0;
    end
  end

  // root and divide datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          rad    <= {head.data.power, POW_W'(0)};
          rem    <= '0;
          root   <= '0;
          last_f <= head.data.last;
          step   <= STEP_W'(ROOT_STEPS - 1);
          if (!head.data.counted) begin
            dvd  <= sum;
            drem <= '0;
            step <= STEP_W'(SUM_W - 1);
          end
        end
      end
      B_ROOT: begin
        rad  <= rad << 2;
        rem  <= rem_new[MAG_W+1:0];
        root <= root_new;
        step <= step - 1'b1;
        if (step == '0) begin
          dvd  <= sum_new;
          drem <= '0;
          step <= STEP_W'(SUM_W - 1);
        end
      end
      B_DIV: begin
        dvd  <= {dvd[SUM_W-2:0], dge};
        drem <= dge ? dr_diff[CNT_W-1:0] : dr_sh[CNT_W-1:0];
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      outv <= 1'b0;
    end else if (load) begin
      outv <= 1'b1;
    end else if (result.ready) begin
      outv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean <= dvd[MAG_W-1:0];
    end
  end

  assign result.valid = outv;
  assign result.mean_magnitude = mean;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bcount <= MAX_COUNT)
    else $error("sample count above limit");

  a_mean_fits: assert property (@(posedge clk) disable iff (rst)
    state == B_OUT |-> dvd[SUM_W-1:MAG_W] == '0)
    else $error("mean does not fit the result field");

  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> sum == '0 && bcount == '0 && outv)
    else $error("block state not cleared after result");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

@@ sv/mean_iq_magnitude.sv @@
// top level of the mean iq magnitude block
//
//   channel   dir   request fields                          accepted when
//   samples   in    in_phase, quadrature, block_end         valid && ready
//   result    out   mean_magnitude (unsigned q8.8)          valid && ready
//
// a counted sample in the back end is popped, then resolves 16 root digits
// a sample past the limit is only popped; a block end adds SUM_W (29) divide
// steps and a load of the result register
// a 4-deep queue lets the front take samples while the back works
// synchronous active-high reset clears the block state, queue and result valid
// a stalled result holds the back end only once a further result is ready
module mean_iq_magnitude import mqm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mqm_in_if.sink    samples,
  mqm_out_if.source result
);

  q_port_t push;
  q_port_t head;
  logic    q_full;
  logic    pop;

  mqm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_full  (q_full),
    .push    (push)
  );

  mqm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  mqm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ verif/mean_iq_magnitude_checker.sv @@
// checker for mean_iq_magnitude: predicts block means from accepted samples and compares results
module mean_iq_magnitude_checker
  import mqm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mqm_in_if         samples,
  mqm_out_if        result,
  output int        fail_count,
  output int        means_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // running block state of the predictor
  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_count;
  logic [MAG_W-1:0] pending_means[$];
  int               report_count;

  // truncated q8.8 magnitude: integer root of (i*i + q*q) << 16
  function automatic logic [MAG_W-1:0] magnitude_q88(input logic signed [IQ_W-1:0] i,
                                                     input logic signed [IQ_W-1:0] q);
    int          ii;
    int          qq;
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    ii = i;
    qq = q;
    rem = 32'(ii * ii + qq * qq) << 16;
    root = '0;
    probe = 32'h4000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[MAG_W-1:0];
  endfunction

  // failure bookkeeping, only the first few are printed
  function automatic void note_failure(input string what, input logic [MAG_W-1:0] want,
                                       input logic [MAG_W-1:0] got);
    fail_count++;
    if (report_count < REPORT_LIMIT) begin
      report_count++;
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endfunction

  initial begin
    fail_count = 0;
    means_waiting = 0;
    report_count = 0;
    acc_sum = '0;
    acc_count = '0;
  end

  always @(posedge clk) begin
    logic [SUM_W-1:0] next_sum;
    logic [CNT_W-1:0] next_count;
    logic [MAG_W-1:0] want;
    if (!rst) begin
      // result request against the oldest predicted mean
      if (result.valid && result.ready) begin
        if (pending_means.size() == 0) begin
          note_failure("unexpected result, none pending", '0, result.mean_magnitude);
        end else begin
          want = pending_means.pop_front();
          if (result.mean_magnitude !== want) begin
            note_failure("mean_magnitude", want, result.mean_magnitude);
          end
        end
      end
      // sample request updates the predicted block state
      if (samples.valid && samples.ready) begin
        next_sum = acc_sum;
        next_count = acc_count;
        if (acc_count < MAX_COUNT) begin
          next_sum = acc_sum + SUM_W'(magnitude_q88(samples.in_phase, samples.quadrature));
          next_count = acc_count + 1'b1;
        end
        if (samples.block_end) begin
          want = (next_count != 0) ? MAG_W'(next_sum / next_count) : '0;
          pending_means.push_back(want);
          next_sum = '0;
          next_count = '0;
        end
        acc_sum <= next_sum;
        acc_count <= next_count;
      end
      means_waiting <= pending_means.size();
    end
  end

endmodule

@@ verif/mean_iq_magnitude_tb.sv @@
// testbench top for mean_iq_magnitude: clock, reset, sample and stall stimulus, verdict
module mean_iq_magnitude_tb import mqm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 530;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RESET_CYCLES = 11;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count;
  int   means_waiting;
  bit   sender_calm = 1'b0;

  mqm_in_if  samples_ch ();
  mqm_out_if result_ch ();

  mean_iq_magnitude DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .result  (result_ch)
  );

  mean_iq_magnitude_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples_ch),
    .result        (result_ch),
    .fail_count    (fail_count),
    .means_waiting (means_waiting)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random component, biased toward the edges now and then
  function automatic logic signed [IQ_W-1:0] rand_iq();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: return -8'sd128;
        1: return 8'sd127;
        2: return 8'sd0;
        3: return -8'sd1;
        default: return 8'sd1;
      endcase
    end
    return IQ_W'($urandom);
  endfunction

  // one sample request, with a random gap ahead of it
  task automatic send_sample(input logic signed [IQ_W-1:0] i,
                             input logic signed [IQ_W-1:0] q,
                             input logic last);
    int gap;
    gap = sender_calm ? 0 : idle_len();
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.in_phase <= i;
    samples_ch.quadrature <= q;
    samples_ch.block_end <= last;
    do @(posedge clk); while (!samples_ch.ready);
    if ($urandom_range(0, 299) == 0) sender_calm = !sender_calm;
  endtask

  // block of random samples, flagged on the last one
  task automatic send_block(input int len);
    for (int k = 0; k < len; k++) begin
      send_sample(rand_iq(), rand_iq(), k == len - 1);
    end
  endtask

  // result side back-pressure, with calm stretches
  initial begin
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (!calm) hold = idle_len();
      end
    end
  end

  // main stimulus
  initial begin
    int sent;
    int len;
    int r;
    samples_ch.valid = 1'b0;
    samples_ch.in_phase = '0;
    samples_ch.quadrature = '0;
    samples_ch.block_end = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // single-sample blocks at the corners
    send_sample(-8'sd128, -8'sd128, 1'b1);
    send_sample(8'sd127, 8'sd127, 1'b1);
    send_sample(8'sd0, 8'sd0, 1'b1);
    send_sample(-8'sd128, 8'sd0, 1'b1);
    send_sample(8'sd0, 8'sd127, 1'b1);
    send_sample(8'sd127, -8'sd128, 1'b1);
    send_sample(8'sd1, 8'sd0, 1'b1);
    send_sample(-8'sd1, -8'sd1, 1'b1);
    send_sample(8'sd0, -8'sd128, 1'b1);
    // short blocks where the mean truncates
    send_sample(8'sd1, 8'sd0, 1'b0);
    send_sample(8'sd1, 8'sd1, 1'b0);
    send_sample(8'sd0, 8'sd0, 1'b1);
    send_sample(8'sd3, -8'sd4, 1'b0);
    send_sample(-8'sd128, -8'sd128, 1'b0);
    send_sample(8'sd85, -8'sd86, 1'b0);
    send_sample(-8'sd43, 8'sd42, 1'b1);
    send_sample(8'sd127, 8'sd127, 1'b0);
    send_sample(-8'sd128, -8'sd128, 1'b1);

    // random blocks, mostly short
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      send_block(len);
      sent += len;
    end

    // a final short block
    send_block($urandom_range(1, 5));

    samples_ch.valid <= 1'b0;
    // let the checker count the last block before waiting on it
    @(posedge clk);
    while (means_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mqm_pkg.sv
sv/mqm_in_if.sv
sv/mqm_out_if.sv
sv/mqm_front.sv
sv/mqm_queue.sv
sv/mqm_back.sv
sv/mean_iq_magnitude.sv
verif/mean_iq_magnitude_checker.sv
verif/mean_iq_magnitude_tb.sv
